// File: hdl/skts_pkg.sv
// Shared types, constants and helpers of the sorted key table search block.
`default_nettype none

package skts_pkg;

    // Field widths
    localparam int KIND_W = 2;
    localparam int KEY_W  = 32;
    localparam int POS_W  = 6;

    // Default table depth
    localparam int MAX_ENTRIES_DEF = 64;

    // Item kind codes
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;

    // One stored table entry: key plus the arrival index it was loaded under
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [POS_W-1:0]        arrival;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // One result item
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic             full_res;
    } res_t;

    // Signed key compare: a < b
    function automatic logic key_less(input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
        key_less = (a < b);
    endfunction

endpackage

`default_nettype wire

// File: hdl/skts_if.sv
// Valid/ready channel interfaces for command and result transfers.
`default_nettype none

interface skts_cmd_if;
    logic                                 valid;
    logic                                 ready;
    logic [skts_pkg::KIND_W-1:0]          kind;
    logic signed [skts_pkg::KEY_W-1:0]    key;

    modport source (output valid, output kind, output key, input ready);
    modport sink   (input valid, input kind, input key, output ready);
endinterface

interface skts_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic [skts_pkg::POS_W-1:0]    position;
    logic                          full_res;

    modport source (output valid, output found, output position, output full_res,
                    input ready);
    modport sink   (input valid, input found, input position, input full_res,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/sorted_key_table_search.sv
// Top level of the sorted key table search block.
`default_nettype none

// Keeps up to MAX_ENTRIES signed 32-bit keys sorted ascending in one RAM, each
// with the arrival index it was loaded under (equal keys stay in arrival order).
// Every command (clear, insert, query) gives exactly one result. The block works
// on one command at a time; the result sits in an output register, so the next
// command is taken while an earlier result waits. The single RAM has registered
// read data. A clear, a dropped insert, an insert into an empty table or an
// unused kind goes straight to its result; any other insert reads down from the
// top entry, shifts the k larger entries up one slot each and then writes the
// new entry; a query makes p probes, where p is at most floor(log2(count))+1.
// An insert into a full table is dropped and flagged with full_res. No clearing
// pass is needed after reset: only entries below the entry count are ever read.
module sorted_key_table_search #(
    parameter int MAX_ENTRIES = skts_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    skts_cmd_if.sink    cmd,
    skts_rsp_if.source  rsp
);

    localparam int ADDR_W = $clog2(MAX_ENTRIES);

    logic                          res_valid;
    logic                          res_ready;
    skts_pkg::res_t                res;
    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [skts_pkg::ENTRY_W-1:0]  ram_wdata;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [skts_pkg::ENTRY_W-1:0]  ram_rdata;

    // Entry store
    skts_ram #(
        .WIDTH (skts_pkg::ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Insert and search sequencer
    skts_ctrl #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // Result output register
    skts_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire

// File: hdl/skts_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module skts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hdl/skts_ctrl.sv
// Sequencer: insertion shifts and binary search probes over the entry RAM.
`default_nettype none

module skts_ctrl #(
    parameter int MAX_ENTRIES = skts_pkg::MAX_ENTRIES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    skts_cmd_if.sink                               cmd,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output skts_pkg::res_t                         res,
    output logic                                   ram_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]         ram_waddr,
    output logic [skts_pkg::ENTRY_W-1:0]           ram_wdata,
    output logic [$clog2(MAX_ENTRIES)-1:0]         ram_raddr,
    input  wire logic [skts_pkg::ENTRY_W-1:0]      ram_rdata
);

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = $clog2(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS,
        ST_PUT,
        ST_QRY,
        ST_DONE
    } state_t;

    state_t                              state_reg, state_next;
    logic [CNT_W-1:0]                    count_reg, count_next;
    logic signed [skts_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [ADDR_W-1:0]                   slot_reg, slot_next;
    logic [CNT_W-1:0]                    lo_reg, lo_next;
    logic [CNT_W-1:0]                    hip1_reg, hip1_next;
    logic [ADDR_W-1:0]                   mid_reg, mid_next;
    skts_pkg::res_t                      res_reg, res_next;

    skts_pkg::entry_t                    rd_entry;
    skts_pkg::entry_t                    new_entry;
    logic [CNT_W:0]                      span_sum;

    assign rd_entry          = skts_pkg::entry_t'(ram_rdata);
    assign new_entry.key     = key_reg;
    assign new_entry.arrival = skts_pkg::POS_W'(count_reg);

    assign cmd.ready = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Next-state and memory access logic
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        key_next   = key_reg;
        slot_next  = slot_reg;
        lo_next    = lo_reg;
        hip1_next  = hip1_reg;
        mid_next   = mid_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_waddr  = slot_reg;
        ram_wdata  = new_entry;
        ram_raddr  = '0;
        span_sum   = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    key_next = cmd.key;
                    res_next = '0;
                    case (cmd.kind)
                        skts_pkg::KIND_CLEAR:
                        begin
                            count_next = '0;
                            state_next = ST_DONE;
                        end
                        skts_pkg::KIND_INSERT:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res_next.full_res = 1'b1;
                                state_next        = ST_DONE;
                            end
                            else if (count_reg == '0)
                            begin
                                // first entry goes straight to slot 0
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                ram_wdata  = {cmd.key, skts_pkg::POS_W'(0)};
                                count_next = CNT_W'(1);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                ram_raddr  = ADDR_W'(count_reg - CNT_W'(1));
                                slot_next  = ADDR_W'(count_reg);
                                state_next = ST_INS;
                            end
                        end
                        skts_pkg::KIND_QUERY:
                        begin
                            if (count_reg == '0)
                            begin
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                lo_next    = '0;
                                hip1_next  = count_reg;
                                span_sum   = {1'b0, count_reg} - (CNT_W+1)'(1);
                                mid_next   = ADDR_W'(span_sum >> 1);
                                ram_raddr  = mid_next;
                                state_next = ST_QRY;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_INS:
            begin
                if (skts_pkg::key_less(key_reg, rd_entry.key))
                begin
                    // shift the larger entry up one slot, read the next one down if there is one
                    ram_we    = 1'b1;
                    ram_waddr = slot_reg;
                    ram_wdata = rd_entry;
                    slot_next = slot_reg - ADDR_W'(1);
                    if (slot_reg == ADDR_W'(1))
                    begin
                        state_next = ST_PUT;
                    end
                    else
                    begin
                        ram_raddr = slot_reg - ADDR_W'(2);
                    end
                end
                else
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = slot_reg;
                    ram_wdata  = new_entry;
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_DONE;
                end
            end

            ST_PUT:
            begin
                ram_we     = 1'b1;
                ram_waddr  = slot_reg;
                ram_wdata  = new_entry;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_DONE;
            end

            ST_QRY:
            begin
                if (rd_entry.key == key_reg)
                begin
                    res_next.found    = 1'b1;
                    res_next.position = rd_entry.arrival;
                    state_next        = ST_DONE;
                end
                else
                begin
                    // narrow the search window, then probe its midpoint if it is not empty
                    if (skts_pkg::key_less(key_reg, rd_entry.key))
                    begin
                        hip1_next = CNT_W'(mid_reg);
                    end
                    else
                    begin
                        lo_next = CNT_W'(mid_reg) + CNT_W'(1);
                    end
                    if (lo_next < hip1_next)
                    begin
                        span_sum  = {1'b0, lo_next} + {1'b0, hip1_next} - (CNT_W+1)'(1);
                        mid_next  = ADDR_W'(span_sum >> 1);
                        ram_raddr = mid_next;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers of the current item
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        slot_reg <= slot_next;
        lo_reg   <= lo_next;
        hip1_reg <= hip1_next;
        mid_reg  <= mid_next;
        res_reg  <= res_next;
    end

endmodule

`default_nettype wire

// File: hdl/skts_obuf.sv
// Output register that holds a finished result until the sink takes it.
`default_nettype none

module skts_obuf (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            res_valid,
    output logic                 res_ready,
    input  wire skts_pkg::res_t  res,
    skts_rsp_if.source           rsp
);

    logic           valid_reg, valid_next;
    skts_pkg::res_t data_reg, data_next;

    assign res_ready = !valid_reg || rsp.ready;

    // Load a new result when the slot is free or being emptied
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (res_valid && res_ready)
        begin
            valid_next = 1'b1;
            data_next  = res;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign rsp.valid    = valid_reg;
    assign rsp.found    = data_reg.found;
    assign rsp.position = data_reg.position;
    assign rsp.full_res = data_reg.full_res;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the sorted key table search block.
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W = skts_pkg::KIND_W;
    localparam int KEY_W = skts_pkg::KEY_W;
    localparam int POS_W = skts_pkg::POS_W;

    localparam int TABLE_DEPTH = skts_pkg::MAX_ENTRIES_DEF;
    localparam int ITEM_TARGET = 1300;
    localparam int TAIL_ITEMS = 150;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 16;

    // Kind code that the block ignores
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fff_ffff;

    typedef struct {
        logic [KIND_W-1:0]       kind;
        logic signed [KEY_W-1:0] key;
        bit                      hold_until_drained;
    } table_cmd_t;

    logic clk;
    logic rst_n;

    skts_cmd_if cmd_ch ();
    skts_rsp_if rsp_ch ();

    sorted_key_table_search dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Stimulus and scoreboard storage
    table_cmd_t              pending_cmds[$];
    skts_pkg::res_t          awaited_results[$];
    logic signed [KEY_W-1:0] stored_key_pool[$];

    // Predictor copy of the table
    logic signed [KEY_W-1:0] shadow_keys[TABLE_DEPTH];
    logic [POS_W-1:0]        shadow_arrival[TABLE_DEPTH];
    int                      shadow_count;

    int  error_count;
    int  session_count;
    int  n_clears, n_inserts, n_dropped, n_queries, n_hits, n_unused, n_results;
    bit  cmd_fired;
    bit  tail_phase;
    bit  idling_on;
    int  calm_left;
    int  gap_left;
    int  stall_left;
    int  quiet_cycles;

    always #5 clk = ~clk;

    // Apply one command to the shadow table and return the result it gives
    function automatic skts_pkg::res_t apply_to_table(input logic [KIND_W-1:0] kind,
                                                      input logic signed [KEY_W-1:0] key);
        skts_pkg::res_t outcome;
        int   slot;
        int   lo;
        int   hi;
        int   mid;
        outcome = '0;
        if (kind == skts_pkg::KIND_CLEAR)
        begin
            shadow_count = 0;
        end
        else if (kind == skts_pkg::KIND_INSERT)
        begin
            if (shadow_count >= TABLE_DEPTH)
            begin
                outcome.full_res = 1'b1;
            end
            else
            begin
                // shift larger keys up, keeping equal keys in arrival order
                slot = shadow_count;
                while (slot > 0 && key < shadow_keys[slot-1])
                begin
                    shadow_keys[slot] = shadow_keys[slot-1];
                    shadow_arrival[slot] = shadow_arrival[slot-1];
                    slot--;
                end
                shadow_keys[slot] = key;
                shadow_arrival[slot] = POS_W'(shadow_count);
                shadow_count++;
            end
        end
        else if (kind == skts_pkg::KIND_QUERY)
        begin
            lo = 0;
            hi = shadow_count - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (shadow_keys[mid] == key)
                begin
                    outcome.found = 1'b1;
                    outcome.position = shadow_arrival[mid];
                    break;
                end
                if (key < shadow_keys[mid])
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
        end
        return outcome;
    endfunction

    function automatic void queue_cmd(input logic [KIND_W-1:0] kind,
                                      input logic signed [KEY_W-1:0] key,
                                      input bit hold);
        table_cmd_t item;
        item.kind = kind;
        item.key = key;
        item.hold_until_drained = hold;
        pending_cmds.push_back(item);
    endfunction

    // Draw a key in one of three flavors: wide random, a tight cluster, or corner values
    function automatic logic signed [KEY_W-1:0] draw_key(input int flavor);
        logic signed [KEY_W-1:0] k;
        case (flavor)
            0: k = $urandom();
            1: k = $signed(KEY_W'($urandom_range(0, 16))) - 32'sd8;
            default:
                case ($urandom_range(0, 7))
                    0: k = KEY_MIN;
                    1: k = KEY_MIN + 32'sd1;
                    2: k = -32'sd1;
                    3: k = 32'sd0;
                    4: k = 32'sd1;
                    5: k = KEY_MAX - 32'sd1;
                    6: k = KEY_MAX;
                    default: k = $urandom();
                endcase
        endcase
        return k;
    endfunction

    // Query key: mostly a stored key, sometimes a neighbor or a fresh draw
    function automatic logic signed [KEY_W-1:0] draw_query(input int flavor);
        logic signed [KEY_W-1:0] k;
        if (stored_key_pool.size() != 0 && $urandom_range(0, 3) != 0)
        begin
            k = stored_key_pool[$urandom_range(0, stored_key_pool.size() - 1)];
            if ($urandom_range(0, 5) == 0)
                k = k + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        end
        else
        begin
            k = draw_key(flavor);
        end
        return k;
    endfunction

    // One session: usually a clear, a run of inserts mixed with queries and unused kinds, then queries
    function automatic void add_session(input bit hold);
        int                      n_ins;
        int                      n_tail_queries;
        int                      flavor;
        logic signed [KEY_W-1:0] k;
        n_ins = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 20);
        n_tail_queries = $urandom_range(2, 10);
        flavor = $urandom_range(0, 2);
        if ($urandom_range(0, 9) != 0 || hold)
        begin
            queue_cmd(skts_pkg::KIND_CLEAR, $urandom(), hold);
            stored_key_pool.delete();
        end
        for (int i = 0; i < n_ins; i++)
        begin
            k = draw_key(flavor);
            queue_cmd(skts_pkg::KIND_INSERT, k, 1'b0);
            stored_key_pool.push_back(k);
            if ($urandom_range(0, 2) == 0)
                queue_cmd(skts_pkg::KIND_QUERY, draw_query(flavor), 1'b0);
            if ($urandom_range(0, 40) == 0)
                queue_cmd(KIND_UNUSED, $urandom(), 1'b0);
        end
        for (int i = 0; i < n_tail_queries; i++)
            queue_cmd(skts_pkg::KIND_QUERY, draw_query(flavor), 1'b0);
    endfunction

    // Drive the command channel from the pending queue
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            gap_left <= 0;
            tail_phase <= 1'b0;
            idling_on <= 1'b1;
            calm_left <= 0;
        end
        else
        begin
            tail_phase <= (pending_cmds.size() < TAIL_ITEMS);
            // alternate stretches with and without idling
            if (calm_left == 0)
            begin
                idling_on <= ($urandom_range(0, 3) != 0);
                calm_left <= $urandom_range(20, 120);
            end
            else
            begin
                calm_left <= calm_left - 1;
            end
            if (cmd_ch.valid && !cmd_fired)
            begin
                // hold the current transfer until it is taken
            end
            else if (gap_left > 0)
            begin
                cmd_ch.valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_cmds.size() == 0)
            begin
                cmd_ch.valid <= 1'b0;
            end
            else if (pending_cmds[0].hold_until_drained && awaited_results.size() != 0)
            begin
                cmd_ch.valid <= 1'b0;
            end
            else if (!tail_phase && idling_on && $urandom_range(0, 5) == 0)
            begin
                cmd_ch.valid <= 1'b0;
                gap_left <= $urandom_range(0, 3);
            end
            else
            begin
                cmd_ch.valid <= 1'b1;
                cmd_ch.kind <= pending_cmds[0].kind;
                cmd_ch.key <= pending_cmds[0].key;
                void'(pending_cmds.pop_front());
            end
        end
    end

    // Stall the result channel in short bursts
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!tail_phase && idling_on && $urandom_range(0, 5) == 0)
        begin
            rsp_ch.ready <= 1'b0;
            stall_left <= $urandom_range(0, 3);
        end
        else
        begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Predict on each command transfer, check each result transfer
    always @(posedge clk or negedge rst_n)
    begin
        skts_pkg::res_t outcome;
        skts_pkg::res_t want;
        if (!rst_n)
        begin
            cmd_fired <= 1'b0;
            shadow_count = 0;
        end
        else
        begin
            cmd_fired <= cmd_ch.valid && cmd_ch.ready;
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                outcome = apply_to_table(cmd_ch.kind, cmd_ch.key);
                awaited_results.push_back(outcome);
                case (cmd_ch.kind)
                    skts_pkg::KIND_CLEAR: n_clears++;
                    skts_pkg::KIND_INSERT:
                    begin
                        n_inserts++;
                        if (outcome.full_res)
                            n_dropped++;
                    end
                    skts_pkg::KIND_QUERY:
                    begin
                        n_queries++;
                        if (outcome.found)
                            n_hits++;
                    end
                    default: n_unused++;
                endcase
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_results++;
                if (awaited_results.size() == 0)
                begin
                    error_count++;
                    $display("%0t: unexpected result transfer found=%0d position=%0d full=%0d",
                             $realtime, rsp_ch.found, rsp_ch.position, rsp_ch.full_res);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_ch.found !== want.found)
                    begin
                        error_count++;
                        $display("%0t: found mismatch, expected %0d, actual %0d",
                                 $realtime, want.found, rsp_ch.found);
                    end
                    if (rsp_ch.position !== want.position)
                    begin
                        error_count++;
                        $display("%0t: position mismatch, expected %0d, actual %0d",
                                 $realtime, want.position, rsp_ch.position);
                    end
                    if (rsp_ch.full_res !== want.full_res)
                    begin
                        error_count++;
                        $display("%0t: full_res mismatch, expected %0d, actual %0d",
                                 $realtime, want.full_res, rsp_ch.full_res);
                    end
                end
            end
        end
    end

    // End the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $realtime, STALL_LIMIT, awaited_results.size());
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.kind = skts_pkg::KIND_CLEAR;
        cmd_ch.key = '0;
        rsp_ch.ready = 1'b0;
        error_count = 0;
        quiet_cycles = 0;

        // Directed: empty table, unused kind, extremes, duplicates, misses, clear
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd0, 1'b0);
        queue_cmd(KIND_UNUSED, -32'sd1, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, KEY_MAX, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, KEY_MIN, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, 32'sd0, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, -32'sd1, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, 32'sd0, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, 32'sd1, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, KEY_MIN, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, KEY_MAX, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd0, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, -32'sd1, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd1, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd2, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, KEY_MIN + 32'sd1, 1'b0);
        queue_cmd(KIND_UNUSED, KEY_MAX, 1'b0);
        queue_cmd(skts_pkg::KIND_CLEAR, KEY_MIN, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd0, 1'b0);
        queue_cmd(skts_pkg::KIND_INSERT, 32'sd5, 1'b0);
        queue_cmd(skts_pkg::KIND_QUERY, 32'sd5, 1'b0);

        // Random sessions; some wait for the block to drain before starting
        session_count = 0;
        while (pending_cmds.size() < ITEM_TARGET)
        begin
            add_session(session_count % 15 == 0);
            session_count++;
        end

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        while (pending_cmds.size() != 0 || cmd_ch.valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Covered %0d sessions: %0d inserts (%0d dropped on a full table),",
                 session_count, n_inserts, n_dropped);
        $display("  %0d queries (%0d hits), %0d clears, %0d unused-kind commands, %0d results",
                 n_queries, n_hits, n_clears, n_unused, n_results);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hdl/skts_pkg.sv
hdl/skts_if.sv
hdl/skts_ram.sv
hdl/skts_ctrl.sv
hdl/skts_obuf.sv
hdl/sorted_key_table_search.sv
test/testbench.sv
